// ----- src/vorf_pkg.sv -----
// Shared constants, codes and types of the voxel occupancy ray fill block.
// Used by the grid memory, the shared multiplier and the top level.
package vorf_pkg;

  localparam int GRID_CELLS = 16;
  localparam int CW         = $clog2(GRID_CELLS);
  localparam int GRID_DEPTH = GRID_CELLS * GRID_CELLS * GRID_CELLS;
  localparam int AW         = $clog2(GRID_DEPTH);

  localparam int CELL_W  = 4;
  localparam int IW      = (CW > CELL_W) ? CW : CELL_W;
  localparam int COORD_W = 24;
  localparam int RES_W   = 16;
  localparam int FL_W    = 24;
  localparam int AD_W    = 24;
  localparam int CNT_W   = 6;

  // Box half-extent arithmetic (all values doubled to stay integer).
  localparam int LIM_W = RES_W + CW + 1;
  localparam int RW    = LIM_W + 1;
  localparam int WW    = LIM_W + 8;
  localparam int NW    = RES_W + CW + 2;
  localparam int DBW   = $clog2(CW + 1);

  // Shared multiplier and the wide products built from its limbs.
  localparam int LIMB_W = 25;
  localparam int PROD_W = 2 * LIMB_W;
  localparam int SQ_W   = 48;
  localparam int WIDE_W = 2 * LIMB_W;
  localparam int ACC_W  = 2 * WIDE_W;

  typedef enum logic [1:0] {
    REQ_INSERT     = 2'd0,
    REQ_CLEAR_BOX  = 2'd1,
    REQ_READ       = 2'd2,
    REQ_CLEAR_GRID = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  localparam logic [1:0] CELL_FREE = 2'd0;
  localparam logic [1:0] CELL_HIT  = 2'd1;
  localparam logic [1:0] CELL_OCC  = 2'd2;

  localparam logic [2:0] REG_CAM_X    = 3'd0;
  localparam logic [2:0] REG_CAM_Y    = 3'd1;
  localparam logic [2:0] REG_CAM_Z    = 3'd2;
  localparam logic [2:0] REG_RES_X    = 3'd3;
  localparam logic [2:0] REG_RES_Y    = 3'd4;
  localparam logic [2:0] REG_RES_Z    = 3'd5;
  localparam logic [2:0] REG_FILL_EN  = 3'd6;
  localparam logic [2:0] REG_FILL_LEN = 3'd7;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [1:0]    data;
  } grid_wr_t;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y,
                                               input logic [CW-1:0] z);
    logic [AW-1:0] a;
    a = (AW'(x) * AW'(GRID_CELLS) + AW'(y)) * AW'(GRID_CELLS) + AW'(z);
    return a;
  endfunction

endpackage

// ----- src/vorf_grid.sv -----
// Voxel grid storage: one write port and one registered read port.
// Depends on vorf_pkg for the grid depth and the write request type.
module vorf_grid import vorf_pkg::*; (
  input  logic          clk,
  input  grid_wr_t      wr,
  input  logic [AW-1:0] raddr,
  output logic [1:0]    rdata
);

  logic [1:0] mem [GRID_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/vorf_mul.sv -----
// Shared unsigned limb multiplier with a registered product.
// Depends on vorf_pkg for the limb and product widths.
module vorf_mul import vorf_pkg::*; (
  input  logic              clk,
  input  logic [LIMB_W-1:0] a,
  input  logic [LIMB_W-1:0] b,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ----- src/voxel_occupancy_ray_fill.sv -----
// Voxel occupancy grid with occlusion ray fill: sequencer, registers and top level.
// Depends on vorf_pkg, vorf_grid and vorf_mul.
//
// Requests arrive on the s_axis channel, one transaction per request, and each
// request gives exactly one result transaction on m_axis. Configuration is
// written through cfg_valid/cfg_index/cfg_data, which is always ready; it is
// meant to change only while no request is in flight.
// The block works on one request at a time. s_axis_tready is high only while
// the sequencer is idle. A box clear writes each cleared cell once; a grid clear
// writes every cell of the grid, one memory write per cycle; an insert marks the
// cell of the point and may then walk the ray on from it, cell by cell.
// Each ray step uses the one shared 25x25 multiplier: it needs six crossing
// products, one square and two 100-bit products built from four limb
// multiplies each, before the one memory write of the cell.
// After reset the block runs a clearing pass over all GRID_CELLS^3 cells (4096)
// of the grid memory and accepts no request meanwhile.
// A finished result sits in an output register; if the receiver stalls, the
// next request is still accepted and worked on, and its result waits in the
// sequencer until the output register is free.
module voxel_occupancy_ray_fill import vorf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: point_x, point_y, point_z, cell_x, cell_y, cell_z,
  //        box_hi_x, box_hi_y, box_hi_z (lowest bit up)
  input  logic [95:0] s_axis_tdata,
  // tuser: req_type, point_ok (lowest bit up)
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: cell_value, cells_filled (lowest bit up)
  output logic [7:0]  m_axis_tdata,
  // tuser: status
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CHK, S_DIV, S_AXEND, S_MARK, S_SQ, S_DD,
    S_PR, S_STEP, S_NSQ, S_WM, S_BOX, S_RD, S_RD2, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [COORD_W-1:0] cam [3];
  logic [RES_W-1:0]          res [3];
  logic                      fill_en;
  logic [FL_W-1:0]           fill_len;

  // Latched request.
  logic signed [COORD_W-1:0] pt [3];
  logic [CELL_W-1:0]         cl [3];

  // Insert and ray state.
  logic [1:0]        ax;
  logic [RW-1:0]     rem;
  logic [DBW-1:0]    db;
  logic [CW-1:0]     key [3];
  logic              spos [3];
  logic              sneg [3];
  logic [NW-1:0]     num [3];
  logic [AD_W-1:0]   ad [3];
  logic [SQ_W-1:0]   adsq [3];
  logic [SQ_W-1:0]   flsq;
  logic [WIDE_W-1:0] dd;
  logic [SQ_W-1:0]   pp [6];
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  aval;
  logic [SQ_W-1:0]   nsq;
  logic [2:0]        k;
  logic [1:0]        sh;
  logic              wph;
  logic              first;
  logic [1:0]        m;
  logic [CNT_W-1:0]  cnt;

  // Box clear sweep.
  logic [IW-1:0] bx, by, bz;
  logic [IW-1:0] blo [3];
  logic [IW-1:0] bhi [3];

  // Clearing pass.
  logic [AW-1:0] sw;
  logic          boot;

  // Result.
  logic [1:0]       r_cell;
  status_t          r_status;
  logic             ov;
  logic [1:0]       o_cell;
  status_t          o_status;
  logic [CNT_W-1:0] o_cnt;

  grid_wr_t      gw;
  logic [AW-1:0] raddr;
  logic [1:0]    rdata;

  logic [LIMB_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  // Combinational helpers.
  logic [IW-1:0]            in_lo [3];
  logic [IW-1:0]            in_hi [3];
  logic                     box_empty;
  logic [LIM_W-1:0]         lim;
  logic signed [WW-1:0]     p2, lims, psum;
  logic                     outside;
  logic [RW-1:0]            dvs;
  logic signed [COORD_W:0]  dlt;
  logic [COORD_W:0]         dabs;
  logic [RES_W:0]           res2;
  logic                     nz [3];
  logic                     t01, t10, t02, t20, t12, t21;
  logic [1:0]               dim, msel, m0;
  logic                     exit_ray;
  logic [WIDE_W-1:0]        dd_sum;
  logic [WIDE_W-1:0]        wa, wb;
  logic [ACC_W-1:0]         acc_sum;
  logic [ACC_W-1:0]         bq;
  logic                     rd_ok;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {o_cnt, o_cell};
  assign m_axis_tuser  = o_status;

  vorf_grid u_grid (
    .clk   (clk),
    .wr    (gw),
    .raddr (raddr),
    .rdata (rdata)
  );

  vorf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign raddr = cell_addr(CW'(cl[0]), CW'(cl[1]), CW'(cl[2]));
  assign rd_ok = (int'(cl[0]) < GRID_CELLS) && (int'(cl[1]) < GRID_CELLS) &&
                 (int'(cl[2]) < GRID_CELLS);

  // Box corners straight from the request: the high corner saturates.
  always_comb begin
    box_empty = 1'b0;
    for (int i = 0; i < 3; i++) begin
      in_lo[i] = IW'(s_axis_tdata[72 + 4*i +: 4]);
      if (int'(s_axis_tdata[84 + 4*i +: 4]) > GRID_CELLS - 1) begin
        in_hi[i] = IW'(GRID_CELLS - 1);
      end else begin
        in_hi[i] = IW'(s_axis_tdata[84 + 4*i +: 4]);
      end
      if (in_lo[i] > in_hi[i]) begin
        box_empty = 1'b1;
      end
    end
  end

  // Bounds test and voxel index of the current axis, in doubled units.
  always_comb begin
    lim     = LIM_W'(res[ax]) * LIM_W'(GRID_CELLS);
    p2      = $signed({{(WW-COORD_W){pt[ax][COORD_W-1]}}, pt[ax]}) <<< 1;
    lims    = $signed({{(WW-LIM_W){1'b0}}, lim});
    outside = (p2 >= lims) || (p2 <= -lims);
    psum    = p2 + lims;
    res2    = {res[ax], 1'b0};
    dvs     = RW'(res2) << db;
    dlt     = $signed({pt[ax][COORD_W-1], pt[ax]}) - $signed({cam[ax][COORD_W-1], cam[ax]});
    dabs    = (dlt < 0) ? COORD_W'(0) - dlt : dlt;
  end

  // Crossing order: t(a,b) means axis a reaches its next face strictly first.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nz[i] = (ad[i] != '0);
    end
    t01 = nz[0] && (!nz[1] || (pp[0] < pp[1]));
    t10 = nz[1] && (!nz[0] || (pp[1] < pp[0]));
    t02 = nz[0] && (!nz[2] || (pp[2] < pp[3]));
    t20 = nz[2] && (!nz[0] || (pp[3] < pp[2]));
    t12 = nz[1] && (!nz[2] || (pp[4] < pp[5]));
    t21 = nz[2] && (!nz[1] || (pp[5] < pp[4]));
    if (t01) begin
      dim = t02 ? 2'd0 : 2'd2;
    end else begin
      dim = t12 ? 2'd1 : 2'd2;
    end
    m0 = t01 ? 2'd0 : 2'd1;
    if ((m0 == 2'd0) ? t20 : t21) begin
      msel = 2'd2;
    end else begin
      msel = m0;
    end
    exit_ray = (spos[dim] && (key[dim] == CW'(GRID_CELLS - 1))) ||
               (sneg[dim] && (key[dim] == '0));
    dd_sum = WIDE_W'(adsq[0]) + WIDE_W'(adsq[1]) + WIDE_W'(adsq[2]);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    wa = wph ? WIDE_W'(flsq) : WIDE_W'(nsq);
    wb = wph ? WIDE_W'(adsq[m]) : dd;
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        case (k)
          3'd0:    begin mul_a = LIMB_W'(ad[0]); mul_b = LIMB_W'(ad[0]); end
          3'd1:    begin mul_a = LIMB_W'(ad[1]); mul_b = LIMB_W'(ad[1]); end
          3'd2:    begin mul_a = LIMB_W'(ad[2]); mul_b = LIMB_W'(ad[2]); end
          default: begin mul_a = LIMB_W'(fill_len); mul_b = LIMB_W'(fill_len); end
        endcase
      end
      S_PR: begin
        case (k)
          3'd0:    begin mul_a = LIMB_W'(num[0]); mul_b = LIMB_W'(ad[1]); end
          3'd1:    begin mul_a = LIMB_W'(num[1]); mul_b = LIMB_W'(ad[0]); end
          3'd2:    begin mul_a = LIMB_W'(num[0]); mul_b = LIMB_W'(ad[2]); end
          3'd3:    begin mul_a = LIMB_W'(num[2]); mul_b = LIMB_W'(ad[0]); end
          3'd4:    begin mul_a = LIMB_W'(num[1]); mul_b = LIMB_W'(ad[2]); end
          default: begin mul_a = LIMB_W'(num[2]); mul_b = LIMB_W'(ad[1]); end
        endcase
      end
      S_NSQ: begin
        mul_a = LIMB_W'(num[msel]);
        mul_b = LIMB_W'(num[msel]);
      end
      S_WM: begin
        mul_a = k[1] ? wa[WIDE_W-1:LIMB_W] : wa[LIMB_W-1:0];
        mul_b = k[0] ? wb[WIDE_W-1:LIMB_W] : wb[LIMB_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Accumulation of limb products at their weight.
  always_comb begin
    case (sh)
      2'd0:    acc_sum = acc + ACC_W'(prod);
      2'd1:    acc_sum = acc + (ACC_W'(prod) << LIMB_W);
      default: acc_sum = acc + (ACC_W'(prod) << (2 * LIMB_W));
    endcase
    bq = {acc_sum[ACC_W-3:0], 2'b00};
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cam[i] <= '0;
        res[i] <= RES_W'(4096);
      end
      fill_en  <= 1'b0;
      fill_len <= FL_W'(65536);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAM_X:    cam[0]   <= cfg_data;
        REG_CAM_Y:    cam[1]   <= cfg_data;
        REG_CAM_Z:    cam[2]   <= cfg_data;
        REG_RES_X:    res[0]   <= cfg_data[RES_W-1:0];
        REG_RES_Y:    res[1]   <= cfg_data[RES_W-1:0];
        REG_RES_Z:    res[2]   <= cfg_data[RES_W-1:0];
        REG_FILL_EN:  fill_en  <= cfg_data[0];
        REG_FILL_LEN: fill_len <= cfg_data;
        default:      fill_en  <= fill_en;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLR;
      boot   <= 1'b1;
      sw     <= '0;
      ov     <= 1'b0;
      gw.en  <= 1'b0;
    end else begin
      gw.en <= 1'b0;
      if (ov && m_axis_tready) begin
        ov <= 1'b0;
      end
      case (state)
        S_CLR: begin
          gw.en   <= 1'b1;
          gw.addr <= sw;
          gw.data <= CELL_FREE;
          sw      <= sw + AW'(1);
          if (sw == AW'(GRID_DEPTH - 1)) begin
            state <= boot ? S_IDLE : S_DONE;
            boot  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            for (int i = 0; i < 3; i++) begin
              pt[i]  <= s_axis_tdata[24*i +: 24];
              cl[i]  <= s_axis_tdata[72 + 4*i +: 4];
              blo[i] <= in_lo[i];
              bhi[i] <= in_hi[i];
            end
            bx       <= in_lo[0];
            by       <= in_lo[1];
            bz       <= in_lo[2];
            r_cell   <= CELL_FREE;
            r_status <= ST_DONE;
            cnt      <= '0;
            ax       <= 2'd0;
            sw       <= '0;
            case (req_t'(s_axis_tuser[1:0]))
              REQ_INSERT: begin
                if (!s_axis_tuser[2]) begin
                  r_status <= ST_INVALID;
                  state    <= S_DONE;
                end else begin
                  state <= S_CHK;
                end
              end
              REQ_CLEAR_BOX:  state <= box_empty ? S_DONE : S_BOX;
              REQ_READ:       state <= S_RD;
              REQ_CLEAR_GRID: state <= S_CLR;
              default:        state <= S_DONE;
            endcase
          end
        end
        S_CHK: begin
          if (outside) begin
            r_status <= ST_OUTSIDE;
            state    <= S_DONE;
          end else begin
            rem     <= psum[RW-1:0];
            db      <= DBW'(CW - 1);
            key[ax] <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem >= dvs) begin
            rem     <= rem - dvs;
            key[ax] <= (key[ax] << 1) | CW'(1);
          end else begin
            key[ax] <= key[ax] << 1;
          end
          if (db == '0) begin
            state <= S_AXEND;
          end else begin
            db <= db - DBW'(1);
          end
        end
        S_AXEND: begin
          spos[ax] <= (dlt > 0);
          sneg[ax] <= (dlt < 0);
          ad[ax]   <= dabs[AD_W-1:0];
          // Distance to the face being approached, doubled.
          if (dlt > 0) begin
            num[ax] <= NW'(res2) - NW'(rem);
          end else if (dlt < 0) begin
            num[ax] <= NW'(rem);
          end else begin
            num[ax] <= '0;
          end
          if (ax == 2'd2) begin
            state <= S_MARK;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_CHK;
          end
        end
        S_MARK: begin
          gw.en   <= 1'b1;
          gw.addr <= cell_addr(key[0], key[1], key[2]);
          gw.data <= CELL_HIT;
          k       <= '0;
          state   <= fill_en ? S_SQ : S_DONE;
        end
        S_SQ: begin
          case (k)
            3'd1:    adsq[0] <= prod[SQ_W-1:0];
            3'd2:    adsq[1] <= prod[SQ_W-1:0];
            3'd3:    adsq[2] <= prod[SQ_W-1:0];
            3'd4:    flsq    <= prod[SQ_W-1:0];
            default: flsq    <= flsq;
          endcase
          if (k == 3'd4) begin
            state <= S_DD;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_DD: begin
          dd    <= dd_sum;
          k     <= '0;
          first <= 1'b1;
          state <= (dd_sum == '0) ? S_DONE : S_PR;
        end
        S_PR: begin
          if (k != '0) begin
            pp[k - 3'd1] <= prod[SQ_W-1:0];
          end
          if (k == 3'd6) begin
            k     <= '0;
            state <= first ? S_STEP : S_NSQ;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_STEP: begin
          if (exit_ray) begin
            state <= S_DONE;
          end else begin
            key[dim] <= spos[dim] ? key[dim] + CW'(1) : key[dim] - CW'(1);
            num[dim] <= num[dim] + NW'({res[dim], 1'b0});
            k        <= '0;
            first    <= 1'b0;
            state    <= S_PR;
          end
        end
        S_NSQ: begin
          if (k == '0) begin
            m <= msel;
            k <= 3'd1;
          end else begin
            nsq   <= prod[SQ_W-1:0];
            k     <= '0;
            acc   <= '0;
            wph   <= 1'b0;
            state <= S_WM;
          end
        end
        S_WM: begin
          sh <= {1'b0, k[1]} + {1'b0, k[0]};
          if (k != '0) begin
            acc <= acc_sum;
          end
          if (k == 3'd4) begin
            k <= '0;
            if (!wph) begin
              aval <= acc_sum;
              acc  <= '0;
              wph  <= 1'b1;
            end else if (aval > bq) begin
              // Far face of this voxel lies beyond the fill length.
              state <= S_DONE;
            end else begin
              gw.en   <= 1'b1;
              gw.addr <= cell_addr(key[0], key[1], key[2]);
              gw.data <= CELL_OCC;
              if (cnt != {CNT_W{1'b1}}) begin
                cnt <= cnt + CNT_W'(1);
              end
              state <= S_STEP;
            end
          end else begin
            k <= k + 3'd1;
          end
        end
        S_BOX: begin
          gw.en   <= 1'b1;
          gw.addr <= cell_addr(CW'(bx), CW'(by), CW'(bz));
          gw.data <= CELL_FREE;
          if (bz != bhi[2]) begin
            bz <= bz + IW'(1);
          end else begin
            bz <= blo[2];
            if (by != bhi[1]) begin
              by <= by + IW'(1);
            end else begin
              by <= blo[1];
              if (bx != bhi[0]) begin
                bx <= bx + IW'(1);
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_RD: state <= S_RD2;
        S_RD2: begin
          r_cell <= rd_ok ? rdata : CELL_FREE;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!ov || m_axis_tready) begin
            ov       <= 1'b1;
            o_cell   <= r_cell;
            o_status <= r_status;
            o_cnt    <= cnt;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A request is taken only by an idle sequencer, which then leaves idle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after a request transaction");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_DONE || m_axis_tuser == ST_OUTSIDE ||
                       m_axis_tuser == ST_INVALID))
    else $error("result carries an undefined status");

  a_fill_only_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[7:2] != '0) |-> m_axis_tuser == ST_DONE)
    else $error("occluded cells reported for a dropped point");

  a_occ_from_ray: assert property (@(posedge clk) disable iff (rst)
    gw.en && (gw.data == CELL_OCC) |-> $past(state == S_WM))
    else $error("occluded cell written outside the ray walk");

endmodule
